FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, held off while reset is low.
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds on the rising clock edge, held off during reset.
`define BDQ_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/bdq_pkg.sv
// Shared constants and codes for the bounded deque.
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CAP_W     = 11;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // Register index taken from the word address.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_PUSHED = 2'd0;
  localparam logic [STAT_W-1:0] ST_POPPED = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERROR  = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/bounded_deque.sv
// Top level of the bounded deque: ring store, index update and APB register.
`default_nettype none

// Bounded deque of signed 32-bit words in a ring of DEPTH entries, of which
// the first "capacity" (APB register at byte address 0, reset 1024, clamped
// to DEPTH) are in use. A transaction is taken at each rising edge with
// start high and busy low; busy stays low, so one command enters every
// cycle. Its result appears on status_o/data_o with done_o high for exactly
// one cycle, the cycle right after the command was taken. This registered
// result follows the read of the single synchronous ring memory: a pop
// computes its slot from the index registers in the accept cycle and the
// registered read data is shown the cycle after. A push writes the ring in
// its accept cycle, so a pop issued right behind it already sees the word.
// The receiver cannot stall: take each result in the cycle done_o is high.
// Commands: 0 push front, 1 push back, 2 pop front, 3 pop back. Status:
// 0 push accepted, 1 popped word valid (data_o holds it), 2 error (push when
// full, pop when empty, or any command at zero capacity); data_o is zero
// unless status is 1. Writing the capacity empties the deque; ring contents
// need no clearing pass, since a pop only reads slots a push wrote.
// Write the capacity only while no command is in flight.
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // command channel
  input  wire                       start,
  output logic                      busy,
  input  wire  [CMD_W-1:0]          command_i,
  input  wire  signed [DATA_W-1:0]  value_i,
  // result channel
  output logic                      done_o,
  output logic [STAT_W-1:0]         status_o,
  output logic signed [DATA_W-1:0]  data_o,
  // configuration port
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [APB_AW-1:0]         paddr,
  input  wire  [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Registers
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [IDX_W-1:0]  back_q, back_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic              done_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic              popped_q;
  logic [DATA_W-1:0] rd_q;

  // Ring memory
  logic [DATA_W-1:0] mem [DEPTH];

  logic             accept;
  logic             cfg_wr;
  logic [CNT_W-1:0] cap_use;
  logic             push_ok;
  logic             pop_ok;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] nxt_idx;

  // Advance an index one step toward higher slots, wrapping inside cap.
  function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] idx,
                                               logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + CNT_W'(1);
    return (n >= cap) ? '0 : n[IDX_W-1:0];
  endfunction

  // Advance an index one step toward lower slots, wrapping inside cap.
  function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] idx,
                                                 logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] m;
    m = cap - CNT_W'(1);
    if (idx == '0 || CNT_W'(idx) >= cap) begin
      return m[IDX_W-1:0];
    end
    return idx - IDX_W'(1);
  endfunction

  // Every command finishes in one pass, so the block never holds one off.
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = APB_DW'(cap_q);

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Clamp the programmed capacity to the ring size.
  assign cap_use = (32'(cap_q) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);

  assign push_ok = (cap_use != '0) && (occ_q < cap_use);
  assign pop_ok  = (cap_use != '0) && (occ_q != '0);

  always_comb begin
    cap_d     = cap_q;
    front_d   = front_q;
    back_d    = back_q;
    occ_d     = occ_q;
    status_d  = ST_ERROR;
    mem_we    = 1'b0;
    mem_waddr = front_q;
    mem_re    = 1'b0;
    mem_raddr = front_q;
    nxt_idx   = front_q;

    if (accept) begin
      case (command_i)
        CMD_PUSH_FRONT: begin
          if (push_ok) begin
            mem_we    = 1'b1;
            mem_waddr = front_q;
            occ_d     = occ_q + CNT_W'(1);
            // First word: open the back side one slot below it.
            if (occ_q == '0) begin
              back_d = step_down(back_q, cap_use);
            end
            front_d  = step_up(front_q, cap_use);
            status_d = ST_PUSHED;
          end
        end
        CMD_PUSH_BACK: begin
          if (push_ok) begin
            mem_we    = 1'b1;
            mem_waddr = back_q;
            occ_d     = occ_q + CNT_W'(1);
            if (occ_q == '0) begin
              front_d = step_up(front_q, cap_use);
            end
            back_d   = step_down(back_q, cap_use);
            status_d = ST_PUSHED;
          end
        end
        CMD_POP_FRONT: begin
          if (pop_ok) begin
            nxt_idx   = step_down(front_q, cap_use);
            front_d   = nxt_idx;
            occ_d     = occ_q - CNT_W'(1);
            // Last word gone: both sides name the same free slot.
            if (occ_q == CNT_W'(1)) begin
              back_d = nxt_idx;
            end
            mem_re    = 1'b1;
            mem_raddr = nxt_idx;
            status_d  = ST_POPPED;
          end
        end
        CMD_POP_BACK: begin
          if (pop_ok) begin
            nxt_idx   = step_up(back_q, cap_use);
            back_d    = nxt_idx;
            occ_d     = occ_q - CNT_W'(1);
            if (occ_q == CNT_W'(1)) begin
              front_d = nxt_idx;
            end
            mem_re    = 1'b1;
            mem_raddr = nxt_idx;
            status_d  = ST_POPPED;
          end
        end
        default: begin
          status_d = ST_ERROR;
        end
      endcase
    end

    // A capacity write drops the contents: empty the deque.
    if (cfg_wr && paddr[2] == REG_CAPACITY) begin
      cap_d   = pwdata[CAP_W-1:0];
      front_d = '0;
      back_d  = '0;
      occ_d   = '0;
    end
  end

  // Control and index state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      front_q  <= '0;
      back_q   <= '0;
      occ_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_PUSHED;
      popped_q <= 1'b0;
    end else begin
      cap_q    <= cap_d;
      front_q  <= front_d;
      back_q   <= back_d;
      occ_q    <= occ_d;
      done_q   <= accept;
      status_q <= status_d;
      popped_q <= accept && (status_d == ST_POPPED);
    end
  end

  // Ring memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= value_i;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = popped_q ? $signed(rd_q) : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/bdq_checker.sv
// Port-level assertion checker for the bounded deque, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bdq_checker
  import bdq_pkg::*;
(
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      start,
  input wire                      busy,
  input wire [CMD_W-1:0]          command_i,
  input wire                      done_o,
  input wire [STAT_W-1:0]         status_o,
  input wire signed [DATA_W-1:0]  data_o
);

  // Each taken transaction produces its result on the next cycle.
  `BDQ_ASSERT(a_result_follows, clk_i, rst_ni, (start && !busy) |=> done_o, "missing result")

  // No result without a transaction taken in the cycle before.
  `BDQ_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start && !busy), "spurious result")

  // A popped word only answers a pop command.
  `BDQ_ASSERT(a_pop_status, clk_i, rst_ni,
    (done_o && status_o == ST_POPPED) |-> $past(command_i == CMD_POP_FRONT ||
    command_i == CMD_POP_BACK), "pop status on a push")

  // Pushes and errors carry zero data.
  `BDQ_NEVER(a_zero_data, clk_i, rst_ni,
    done_o && status_o != ST_POPPED && data_o != '0, "nonzero data without pop")

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .command_i (command_i),
  .done_o    (done_o),
  .status_o  (status_o),
  .data_o    (data_o)
);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the bounded deque: directed and random command traffic.
`timescale 1ns / 100ps

module testbench;
  import bdq_pkg::*;

  localparam int unsigned RING_DEPTH  = DEPTH_DEF;
  localparam int unsigned REG_SPARE   = 1;   // word index with no register behind it
  localparam int unsigned MAX_REPORTS = 10;

  // One result as the block presents it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
  } outcome_t;

  // Tracks the deque contents and the results still owed by the block.
  class deque_tracker;
    logic [DATA_W-1:0] ring [RING_DEPTH];
    int unsigned       front_free;
    int unsigned       back_free;
    int unsigned       held;
    logic [CAP_W-1:0]  capacity;
    outcome_t          owed [$];
    int unsigned       failures;

    function new();
      foreach (ring[i]) ring[i] = '0;
      capacity = CAP_RESET;
      front_free = 0;
      back_free = 0;
      held = 0;
      failures = 0;
    endfunction

    // A capacity write empties the deque; ring contents stay but are unreachable.
    function void set_capacity(logic [APB_DW-1:0] wdata);
      capacity = wdata[CAP_W-1:0];
      front_free = 0;
      back_free = 0;
      held = 0;
    endfunction

    function int unsigned slots();
      return (capacity > RING_DEPTH) ? RING_DEPTH : int'(capacity);
    endfunction

    function int unsigned ring_up(int unsigned idx, int unsigned cap);
      return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function int unsigned ring_down(int unsigned idx, int unsigned cap);
      return (idx == 0 || idx >= cap) ? cap - 1 : idx - 1;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void complain(string what, outcome_t want, outcome_t got);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s: expected status %0d data %h, got status %0d data %h",
                 $realtime, what, want.status, want.data, got.status, got.data);
    endfunction

    // Advance the deque by one accepted command and queue the result it owes.
    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
      int unsigned cap;
      outcome_t    res;
      cap = slots();
      res.status = ST_ERROR;
      res.data = '0;
      if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
        if (cap != 0 && held < cap) begin
          held++;
          if (cmd == CMD_PUSH_FRONT) begin
            ring[front_free] = word;
            // the first word pushes both free slots apart
            if (held == 1) back_free = ring_down(back_free, cap);
            front_free = ring_up(front_free, cap);
          end else begin
            ring[back_free] = word;
            if (held == 1) front_free = ring_up(front_free, cap);
            back_free = ring_down(back_free, cap);
          end
          res.status = ST_PUSHED;
        end
      end else if (cap != 0 && held != 0) begin
        held--;
        if (cmd == CMD_POP_FRONT) begin
          front_free = ring_down(front_free, cap);
          // emptied: both sides name the same free slot again
          if (held == 0) back_free = front_free;
          res.data = ring[front_free];
        end else begin
          back_free = ring_up(back_free, cap);
          if (held == 0) front_free = back_free;
          res.data = ring[back_free];
        end
        res.status = ST_POPPED;
      end
      owed.insert(owed.size(), res);
    endfunction

    // Compare one strobed result with the oldest owed one.
    function void check_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data);
      outcome_t got;
      outcome_t want;
      got.status = status;
      got.data = data;
      if (owed.size() == 0) begin
        want = '0;
        complain("result with nothing owed", want, got);
        return;
      end
      want = owed[0];
      owed.delete(0);
      if (got.status !== want.status || got.data !== want.data)
        complain("result mismatch", want, got);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         command_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     done_o;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] data_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  deque_tracker tracker = new();

  bounded_deque u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .value_i   (value_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .data_o    (data_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk_i = ~clk_i;

  // Check every strobed result at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(status_o, data_o);
  end

  // Present one command at the falling edge and hold it until the block takes it.
  // Leave start high on return, so a back-to-back transaction needs no second drive.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] word);
    @(negedge clk_i);
    start <= 1'b1;
    command_i <= cmd;
    value_i <= word;
    do @(posedge clk_i); while (busy);
    tracker.note_command(cmd, word);
  endtask

  // Idle the command side; scramble the payload so it is clearly ignored.
  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
      command_i <= CMD_W'($urandom);
      value_i <= $urandom;
    end
  endtask

  // Drop start and wait until every owed result has come.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the data when pready is high.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] wdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[APB_AW-1:2] == REG_CAPACITY) tracker.set_capacity(wdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write the capacity while idle, then read it back.
  task automatic configure(input logic [APB_DW-1:0] cap_word);
    logic [APB_AW-1:0] cap_addr;
    outcome_t          want;
    outcome_t          got;
    cap_addr = {REG_CAPACITY, 2'b00};
    drain();
    apb_write(cap_addr, cap_word);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= cap_addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = '0;
    got = '0;
    want.data = DATA_W'(tracker.capacity);
    got.data = prdata;
    if (got.data !== want.data) tracker.complain("capacity readback", want, got);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Set the capacity, then issue random commands in runs of varying push bias.
  // The first fill_items commands are pushes only, to reach full at large sizes.
  task automatic run_phase(input logic [APB_DW-1:0] cap_word, input int unsigned items,
                           input int unsigned fill_items);
    int unsigned      push_pct;
    int unsigned      run_left;
    bit               burst;
    logic [CMD_W-1:0] cmd;
    push_pct = 50;
    run_left = 0;
    burst = 1'b0;
    configure(cap_word);
    for (int unsigned n = 0; n < items; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: begin
            push_pct = 15;
          end
          1: begin
            push_pct = 50;
          end
          default: begin
            push_pct = 85;
          end
        endcase
        // Run some stretches back to back, idling only for an occasional drain.
        burst = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      if (n < fill_items || $urandom_range(1, 100) <= push_pct)
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      send_command(cmd, $urandom);
      // Now and then pause until the block has nothing left in flight.
      if ($urandom_range(0, 59) == 0) drain();
      else if (!burst) hold_off($urandom_range(0, 14));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CMD_PUSH_FRONT;
    value_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset capacity: empty pops, extreme words, both sides,
    // back-to-back push then pop so the pop must see the word just written.
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '1);
    send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_command(CMD_PUSH_BACK, 32'h8000_0000);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_PUSH_BACK, '0);
    send_command(CMD_PUSH_BACK, '1);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_PUSH_FRONT, 32'h5555_5555);
    send_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_BACK, '0);

    // Capacity of one: full after one push, empty after one pop.
    configure(1);
    send_command(CMD_PUSH_BACK, 32'h1234_5678);
    send_command(CMD_PUSH_FRONT, 32'h0BAD_F00D);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);

    // Zero capacity: every command is an error.
    configure(0);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_0000);
    send_command(CMD_PUSH_BACK, 32'h0000_FFFF);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);

    // A write to an unmapped register must neither change the capacity nor empty the deque.
    configure(2);
    send_command(CMD_PUSH_FRONT, 32'hC0DE_0001);
    send_command(CMD_PUSH_BACK, 32'hC0DE_0002);
    drain();
    apb_write(APB_AW'(4 * REG_SPARE), 32'h0000_0003);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_FRONT, '0);

    // Random part over small, clamped and extreme capacities.
    run_phase(1, 50, 0);
    run_phase(2, 60, 0);
    run_phase(3, 60, 0);
    run_phase(8, 100, 0);
    run_phase($urandom_range(4, 40), 120, 0);
    run_phase(32'hFFFF_FFFF, 1090, 1030);       // clamps to the full ring; fill past full
    run_phase(0, 20, 0);
    run_phase(1025, 80, 0);
    run_phase({21'($urandom), 11'($urandom_range(4, 40))}, 120, 0);

    // Let the last results arrive, then count anything still owed as a failure.
    @(negedge clk_i);
    start <= 1'b0;
    for (int unsigned w = 0; w < 200 && tracker.pending() != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, tracker.pending());
      tracker.failures += tracker.pending();
    end
    if (tracker.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
